/* hw/rtl/qat_pkg.sv */
// Shared types and constants of the quoted argument tokenizer.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package qat_pkg;

	localparam int MAX_BYTES = 4096;
	localparam int MAX_PARTS = 64;

	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 3;
	localparam int OFFSET_W = 12;
	localparam int LENGTH_W = 13;
	localparam int TOTAL_W  = 7;
	localparam int POS_W    = 13;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5c;
	localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;

	localparam logic [TOTAL_W-1:0] MAX_COMPONENTS_RESET = 7'd64;

	// register index on the configuration port
	localparam logic REG_MAX_COMPONENTS = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		K_COMPONENT    = 3'd0,
		K_DONE         = 3'd1,
		K_TOO_MANY     = 3'd2,
		K_UNTERMINATED = 3'd3,
		K_TOO_LONG     = 3'd4
	} kind_t;

	// error register holds the result kind of the pending error, this one when clean
	localparam kind_t NO_ERROR = K_COMPONENT;

	typedef enum logic [2:0] {
		PH_BETWEEN   = 3'd0,
		PH_BACKSLASH = 3'd1,
		PH_BARE      = 3'd2,
		PH_QOPEN     = 3'd3,
		PH_QUOTED    = 3'd4
	} phase_t;

	typedef struct packed {
		kind_t                kind;
		logic [OFFSET_W-1:0]  offset;
		logic [LENGTH_W-1:0]  length;
		logic [TOTAL_W-1:0]   total;
		logic                 end_of_run;
	} result_t;

	// up to two results written into the output queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

`default_nettype wire

/* hw/rtl/qat_in_if.sv */
// Byte channel of the quoted argument tokenizer: valid/ready with byte and last flag.
// Depends on qat_pkg for field widths.
`default_nettype none

interface qat_in_if;
	logic                        valid;
	logic                        ready;
	logic [qat_pkg::BYTE_W-1:0]  byte_value;
	logic                        last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/qat_out_if.sv */
// Result channel of the quoted argument tokenizer: valid/ready with one result.
// Depends on qat_pkg for field widths.
`default_nettype none

interface qat_out_if;
	logic                          valid;
	logic                          ready;
	logic [qat_pkg::KIND_W-1:0]    result_kind;
	logic [qat_pkg::OFFSET_W-1:0]  token_offset;
	logic [qat_pkg::LENGTH_W-1:0]  token_length;
	logic [qat_pkg::TOTAL_W-1:0]   component_total;
	logic                          end_of_run;

	modport source (output valid, output result_kind, output token_offset,
		output token_length, output component_total, output end_of_run, input ready);
	modport sink   (input valid, input result_kind, input token_offset,
		input token_length, input component_total, input end_of_run, output ready);
endinterface

`default_nettype wire

/* hw/rtl/qat_cfg.sv */
// APB-style register file of the tokenizer: holds max_components.
// Depends on qat_pkg.
`default_nettype none

module qat_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [qat_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [qat_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [qat_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output logic      [qat_pkg::TOTAL_W-1:0]     max_components
);
	import qat_pkg::*;

	logic [TOTAL_W-1:0] max_components_q;
	logic               reg_sel;
	logic               wr_en;

	assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_MAX_COMPONENTS);
	assign wr_en   = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_components_q <= MAX_COMPONENTS_RESET;
		end else if (wr_en) begin
			max_components_q <= pwdata[TOTAL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[TOTAL_W-1:0] = max_components_q;
		end
	end

	assign max_components = max_components_q;

endmodule

`default_nettype wire

/* hw/rtl/qat_scan.sv */
// Scanner of the tokenizer: input register, run state and the per-byte update
// that produces up to two results. Depends on qat_pkg and qat_in_if.
`default_nettype none

module qat_scan (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	qat_in_if.sink                            data_ch,
	input  wire logic [qat_pkg::TOTAL_W-1:0]  max_components,
	input  wire logic                         room,
	output qat_pkg::push_t                    push
);
	import qat_pkg::*;

	// input register
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               last_s1;

	// run state
	phase_t               phase_q,  phase_d;
	logic [POS_W-1:0]     pos_q,    pos_d;
	logic [OFFSET_W-1:0]  start_q,  start_d;
	logic [LENGTH_W-1:0]  len_q,    len_d;
	logic [TOTAL_W-1:0]   found_q,  found_d;
	kind_t                err_q,    err_d;

	logic                 fire;
	logic [TOTAL_W-1:0]   limit;
	logic                 comp_valid;
	logic [OFFSET_W-1:0]  comp_off;
	logic [LENGTH_W-1:0]  comp_len;
	logic [TOTAL_W-1:0]   found_sum;
	// error code of this byte's done result, before the run is cleared
	kind_t                err_run;
	result_t              comp_res;
	result_t              done_res;

	assign fire          = valid_s1 && room;
	assign data_ch.ready = !valid_s1 || room;

	assign limit = (max_components < TOTAL_W'(MAX_PARTS)) ? max_components
		: TOTAL_W'(MAX_PARTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ch.ready) begin
			valid_s1 <= data_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ch.ready && data_ch.valid) begin
			byte_s1 <= data_ch.byte_value;
			last_s1 <= data_ch.last_byte;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		start_d    = start_q;
		len_d      = len_q;
		err_d      = err_q;
		comp_valid = 1'b0;
		comp_off   = start_q;
		comp_len   = len_q;

		if (err_q == NO_ERROR && pos_q >= POS_W'(MAX_BYTES)) begin
			err_d = K_TOO_LONG;
		end

		if (err_d == NO_ERROR) begin
			pos_d = pos_q + 1'b1;
			case (phase_q)
				PH_BETWEEN: begin
					if (byte_s1 != CH_SPACE) begin
						if (found_q >= limit) begin
							err_d = K_TOO_MANY;
						end else begin
							start_d = pos_q[OFFSET_W-1:0];
							len_d   = LENGTH_W'(1);
							if (byte_s1 == CH_BACKSLASH) begin
								phase_d = PH_BACKSLASH;
							end else if (byte_s1 == CH_QUOTE) begin
								phase_d = PH_QOPEN;
							end else begin
								phase_d = PH_BARE;
							end
						end
					end
				end
				PH_BACKSLASH: begin
					comp_valid = 1'b1;
					comp_len   = (byte_s1 == CH_SPACE) ? LENGTH_W'(1) : LENGTH_W'(2);
					phase_d    = PH_BETWEEN;
				end
				PH_BARE: begin
					if (byte_s1 == CH_SPACE) begin
						comp_valid = 1'b1;
						phase_d    = PH_BETWEEN;
					end else begin
						len_d = len_q + 1'b1;
					end
				end
				PH_QOPEN: begin
					if (byte_s1 == CH_QUOTE) begin
						phase_d = PH_BETWEEN;
					end else begin
						start_d = pos_q[OFFSET_W-1:0];
						len_d   = LENGTH_W'(1);
						phase_d = PH_QUOTED;
					end
				end
				PH_QUOTED: begin
					if (byte_s1 == CH_QUOTE) begin
						comp_valid = 1'b1;
						phase_d    = PH_BETWEEN;
					end else begin
						len_d = len_q + 1'b1;
					end
				end
				default: begin
					phase_d = PH_BETWEEN;
				end
			endcase
		end

		// close an open word at the last byte; a component from the byte itself
		// always leaves the phase between components, so at most one fires
		if (last_s1 && err_d == NO_ERROR) begin
			case (phase_d)
				PH_BARE: begin
					comp_valid = 1'b1;
					comp_off   = start_d;
					comp_len   = len_d;
				end
				PH_BACKSLASH: begin
					comp_valid = 1'b1;
					comp_off   = start_d;
					comp_len   = LENGTH_W'(1);
				end
				PH_QOPEN, PH_QUOTED: begin
					err_d = K_UNTERMINATED;
				end
				default: begin
				end
			endcase
		end

		found_sum = found_q + TOTAL_W'(comp_valid);
		found_d   = found_sum;
		err_run   = err_d;

		// clear the run after the done result
		if (last_s1) begin
			phase_d = PH_BETWEEN;
			pos_d   = '0;
			start_d = '0;
			len_d   = '0;
			found_d = '0;
			err_d   = NO_ERROR;
		end
	end

	always_comb begin
		comp_res            = '0;
		comp_res.kind       = K_COMPONENT;
		comp_res.offset     = comp_off;
		comp_res.length     = comp_len;

		done_res            = '0;
		done_res.kind       = (err_run != NO_ERROR) ? err_run : K_DONE;
		done_res.total      = found_sum;
		done_res.end_of_run = 1'b1;

		push = '0;
		if (fire) begin
			if (comp_valid) begin
				push.first  = comp_res;
				push.second = done_res;
				push.count  = last_s1 ? 2'd2 : 2'd1;
			end else if (last_s1) begin
				push.first = done_res;
				push.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BETWEEN;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			found_q <= '0;
			err_q   <= NO_ERROR;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			found_q <= found_d;
			err_q   <= err_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/qat_out_fifo.sv */
// Four-entry result queue of the tokenizer: takes up to two results a cycle,
// hands out one per transaction. Depends on qat_pkg and qat_out_if.
`default_nettype none

module qat_out_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire qat_pkg::push_t  push,
	output logic                 room,
	qat_out_if.source            result_ch
);
	import qat_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;
	logic [CNT_W-1:0]   count_after_pop;
	result_t            head_res;

	assign pop             = result_ch.valid && result_ch.ready;
	assign count_after_pop = count_q - CNT_W'(pop);
	// a byte may leave two results; take it only with two free slots
	assign room            = (count_after_pop <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[tail_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[tail_q + PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + PTR_W'(pop);
			tail_q  <= tail_q + PTR_W'(push.count);
			count_q <= count_after_pop + CNT_W'(push.count);
		end
	end

	assign head_res                  = mem_q[head_q];
	assign result_ch.valid           = (count_q != '0);
	assign result_ch.result_kind     = head_res.kind;
	assign result_ch.token_offset    = head_res.offset;
	assign result_ch.token_length    = head_res.length;
	assign result_ch.component_total = head_res.total;
	assign result_ch.end_of_run      = head_res.end_of_run;

endmodule

`default_nettype wire

/* hw/rtl/quoted_argument_tokenizer_top.sv */
// Top level of the quoted argument tokenizer: register port, scanner and result queue.
// Depends on qat_pkg, qat_in_if, qat_out_if, qat_cfg, qat_scan and qat_out_fifo.
`default_nettype none

// Splits a byte string into components, one byte per transaction on data_ch
// with last_byte on the final byte. Spaces separate components; a backslash
// and the byte after it form one component, the backslash alone if that byte
// is a space; a quoted string yields its contents, an empty one no component;
// anything else runs to the next space. Each component leaves one transaction
// on result_ch with its offset and length, and after the last byte a done
// transaction carries the count or the error code (too many components,
// unterminated quote, string longer than MAX_BYTES). A byte lands in the input
// register; from there the scanner updates the run state and writes zero, one
// or two results into a four-entry queue. The scanner accepts one byte per
// cycle as long as the queue has two free slots, so sustained throughput is
// one byte per cycle while result_ch keeps up. Write max_components
// (address 0) only while the block is idle.
module quoted_argument_tokenizer_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	qat_in_if.sink                               data_ch,
	qat_out_if.source                            result_ch,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [qat_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [qat_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [qat_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready
);
	import qat_pkg::*;

	logic [TOTAL_W-1:0] max_components;
	logic               room;
	push_t              push;

	// hold the component limit
	qat_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.max_components (max_components)
	);

	// advance the run state one byte per cycle while the queue has room
	qat_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_ch        (data_ch),
		.max_components (max_components),
		.room           (room),
		.push           (push)
	);

	// queue results so a stalled consumer does not block the scanner at once
	qat_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.result_ch (result_ch)
	);

endmodule

`default_nettype wire
